/* design/cpi_pkg.sv */
// Shared types and constants of the calibration point interpolator.
// Used by the channel interfaces and the top level; depends on nothing.
`default_nettype none

package cpi_pkg;

  // Number of calibration point slots in the register map
  localparam int MAX_POINTS   = 4;
  localparam int RAW_W        = 16;
  localparam int TRUE_W       = 32;

  // Configuration port
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 32;
  localparam logic [CFG_IDX_W-1:0] REG_RAW_BASE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRUE_BASE = 3'd4;

  // Result case codes
  localparam int CODE_W = 3;
  localparam logic [CODE_W-1:0] CASE_EXACT      = 3'd0;
  localparam logic [CODE_W-1:0] CASE_NO_POINTS  = 3'd1;
  localparam logic [CODE_W-1:0] CASE_EXTRAP_TWO = 3'd2;
  localparam logic [CODE_W-1:0] CASE_ORIGIN_HI  = 3'd3;
  localparam logic [CODE_W-1:0] CASE_ORIGIN_LO  = 3'd4;
  localparam logic [CODE_W-1:0] CASE_INTERP     = 3'd5;

  // Datapath widths: offset x |rise| product, dividend and divider steps
  localparam int RISE_W    = TRUE_W + 1;
  localparam int PROD_W    = RAW_W + RISE_W;
  localparam int DIV_W     = 50;
  localparam int DIV_STEPS = DIV_W / 2;
  localparam int CNT_W     = 5;
  localparam int SUM_W     = DIV_W + 2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SETUP,
    ST_MULT,
    ST_DIV,
    ST_FINISH
  } cpi_state_t;

endpackage : cpi_pkg

`default_nettype wire

/* design/cpi_in_if.sv */
// Input channel of the interpolator: one raw sample per request.
// Depends on cpi_pkg.
`default_nettype none

interface cpi_in_if;
  import cpi_pkg::*;

  logic             valid;
  logic             ready;
  logic [RAW_W-1:0] raw_sample;

  modport source (output valid, output raw_sample, input ready);
  modport sink   (input valid, input raw_sample, output ready);
endinterface : cpi_in_if

`default_nettype wire

/* design/cpi_out_if.sv */
// Result channel of the interpolator: calibrated value, case code, clip flag.
// Depends on cpi_pkg.
`default_nettype none

interface cpi_out_if;
  import cpi_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [TRUE_W-1:0] calibrated_value;
  logic [CODE_W-1:0]        case_code;
  logic                     saturated;

  modport source (output valid, output calibrated_value, output case_code,
                  output saturated, input ready);
  modport sink   (input valid, input calibrated_value, input case_code,
                  input saturated, output ready);
endinterface : cpi_out_if

`default_nettype wire

/* design/calibration_point_interpolator.sv */
// Piecewise linear calibration of raw samples against configured points.
// Depends on cpi_pkg, cpi_in_if and cpi_out_if.
// One request is processed at a time; the next is accepted only once the result
//   is in the output register. An exact match or no point in use skips the multiply
//   and divide steps; the point scan takes one point a cycle and the 50-bit divider
//   retires two bits a cycle.
// A finished result waits in the output register while the next request is taken.
// Reset (rst_n low, synchronous) clears all points to zero and empties the block.
`default_nettype none

module calibration_point_interpolator #(
  parameter int NUM_POINTS = cpi_pkg::MAX_POINTS
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  cpi_in_if.sink                              in_ch,
  cpi_out_if.source                           out_ch,
  input  wire                                 cfg_we,
  input  wire  [cpi_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire  [cpi_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import cpi_pkg::*;

  localparam int IDX_W = (NUM_POINTS > 1) ? $clog2(NUM_POINTS) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_POINTS - 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

  // Calibration point registers
  logic [RAW_W-1:0]         raw_r  [NUM_POINTS];
  logic signed [TRUE_W-1:0] true_r [NUM_POINTS];

  // Sequencer and datapath registers
  cpi_state_t               state_r, state_nxt;
  logic [RAW_W-1:0]         sample_r, sample_nxt;
  logic [IDX_W-1:0]         idx_r, idx_nxt;
  logic                     any_r, any_nxt;
  logic                     match_r, match_nxt;
  logic signed [TRUE_W-1:0] match_true_r, match_true_nxt;
  logic                     lo_v_r, lo_v_nxt;
  logic [RAW_W-1:0]         lo_raw_r, lo_raw_nxt;
  logic signed [TRUE_W-1:0] lo_true_r, lo_true_nxt;
  logic                     lo2_v_r, lo2_v_nxt;
  logic [RAW_W-1:0]         lo2_raw_r, lo2_raw_nxt;
  logic signed [TRUE_W-1:0] lo2_true_r, lo2_true_nxt;
  logic                     hi_v_r, hi_v_nxt;
  logic [RAW_W-1:0]         hi_raw_r, hi_raw_nxt;
  logic signed [TRUE_W-1:0] hi_true_r, hi_true_nxt;
  logic [CODE_W-1:0]        code_r, code_nxt;
  logic signed [TRUE_W-1:0] base_r, base_nxt;
  logic                     neg_r, neg_nxt;
  logic [RAW_W-1:0]         off_r, off_nxt;
  logic [RISE_W-1:0]        rise_r, rise_nxt;
  logic [RAW_W-1:0]         run_r, run_nxt;
  logic [DIV_W-1:0]         quo_r, quo_nxt;
  logic [RAW_W-1:0]         rem_r, rem_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic signed [TRUE_W-1:0] out_value_r, out_value_nxt;
  logic [CODE_W-1:0]        out_code_r, out_code_nxt;
  logic                     out_sat_r, out_sat_nxt;

  logic                     in_acc;
  logic                     out_free;
  logic [RAW_W-1:0]         cur_raw;
  logic signed [TRUE_W-1:0] cur_true;
  logic                     cur_used;
  logic signed [RISE_W-1:0] rise_s;
  logic [PROD_W-1:0]        prod;
  logic [RAW_W:0]           t1, t2;
  logic                     ge1, ge2;
  logic [RAW_W-1:0]         r1, r2;
  logic                     arith;
  logic                     rnd;
  logic [DIV_W-1:0]         q_rnd;
  logic signed [DIV_W:0]    sq;
  logic signed [SUM_W-1:0]  sum;
  logic                     sat_hi, sat_lo;
  logic [RAW_W-1:0]         cfg_slot;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  assign in_ch.ready           = (state_r == ST_IDLE);
  assign out_ch.valid          = out_valid_r;
  assign out_ch.calibrated_value = out_value_r;
  assign out_ch.case_code      = out_code_r;
  assign out_ch.saturated      = out_sat_r;

  // Configuration writes; slots at or beyond NUM_POINTS are never stored
  assign cfg_slot = RAW_W'(cfg_index[1:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_POINTS; i++) begin
        raw_r[i]  <= '0;
        true_r[i] <= '0;
      end
    end else if (cfg_we && (int'(cfg_slot) < NUM_POINTS)) begin
      if (cfg_index < REG_TRUE_BASE) begin
        raw_r[cfg_slot[IDX_W-1:0]]  <= cfg_data[RAW_W-1:0];
      end else begin
        true_r[cfg_slot[IDX_W-1:0]] <= cfg_data[TRUE_W-1:0];
      end
    end
  end

  // Point under scan
  assign cur_raw  = raw_r[idx_r];
  assign cur_true = true_r[idx_r];
  assign cur_used = (cur_raw != '0);

  // Shared multiplier and divider step pair
  assign prod = off_r * rise_r;

  assign t1  = {rem_r, quo_r[DIV_W-1]};
  assign ge1 = (t1 >= {1'b0, run_r});
  assign r1  = ge1 ? RAW_W'(t1 - {1'b0, run_r}) : t1[RAW_W-1:0];
  assign t2  = {r1, quo_r[DIV_W-2]};
  assign ge2 = (t2 >= {1'b0, run_r});
  assign r2  = ge2 ? RAW_W'(t2 - {1'b0, run_r}) : t2[RAW_W-1:0];

  // Round half away from zero, apply sign, add base, saturate
  assign arith  = (code_r != CASE_EXACT) && (code_r != CASE_NO_POINTS);
  assign rnd    = arith && ({rem_r, 1'b0} >= {1'b0, run_r});
  assign q_rnd  = quo_r + DIV_W'(rnd);
  assign sq     = neg_r ? -$signed({1'b0, q_rnd}) : $signed({1'b0, q_rnd});
  assign sum    = $signed({{(SUM_W-TRUE_W){base_r[TRUE_W-1]}}, base_r})
                + $signed({sq[DIV_W], sq});
  assign sat_hi = !sum[SUM_W-1] && (|sum[SUM_W-2:TRUE_W-1]);
  assign sat_lo = sum[SUM_W-1] && !(&sum[SUM_W-2:TRUE_W-1]);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (idx_r == IDX_LAST) state_nxt = ST_SETUP;
      end
      ST_SETUP: begin
        if (match_r || !any_r) state_nxt = ST_FINISH;
        else                   state_nxt = ST_MULT;
      end
      ST_MULT: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (cnt_r == CNT_LAST) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Datapath updates per state
  always_comb begin
    sample_nxt     = sample_r;
    idx_nxt        = idx_r;
    any_nxt        = any_r;
    match_nxt      = match_r;
    match_true_nxt = match_true_r;
    lo_v_nxt       = lo_v_r;
    lo_raw_nxt     = lo_raw_r;
    lo_true_nxt    = lo_true_r;
    lo2_v_nxt      = lo2_v_r;
    lo2_raw_nxt    = lo2_raw_r;
    lo2_true_nxt   = lo2_true_r;
    hi_v_nxt       = hi_v_r;
    hi_raw_nxt     = hi_raw_r;
    hi_true_nxt    = hi_true_r;
    code_nxt       = code_r;
    base_nxt       = base_r;
    neg_nxt        = neg_r;
    off_nxt        = off_r;
    rise_nxt       = rise_r;
    run_nxt        = run_r;
    quo_nxt        = quo_r;
    rem_nxt        = rem_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_value_nxt  = out_value_r;
    out_code_nxt   = out_code_r;
    out_sat_nxt    = out_sat_r;
    rise_s         = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          sample_nxt = in_ch.raw_sample;
          idx_nxt    = '0;
          any_nxt    = 1'b0;
          match_nxt  = 1'b0;
          lo_v_nxt   = 1'b0;
          lo2_v_nxt  = 1'b0;
          hi_v_nxt   = 1'b0;
        end
      end

      // One point a cycle: first exact match, two nearest lesser, nearest greater
      ST_SCAN: begin
        idx_nxt = idx_r + IDX_W'(1);
        if (cur_used) begin
          any_nxt = 1'b1;
          if (cur_raw == sample_r && !match_r) begin
            match_nxt      = 1'b1;
            match_true_nxt = cur_true;
          end
          if (cur_raw < sample_r) begin
            if (!lo_v_r || cur_raw > lo_raw_r) begin
              lo2_v_nxt    = lo_v_r;
              lo2_raw_nxt  = lo_raw_r;
              lo2_true_nxt = lo_true_r;
              lo_v_nxt     = 1'b1;
              lo_raw_nxt   = cur_raw;
              lo_true_nxt  = cur_true;
            end else if (cur_raw < lo_raw_r && (!lo2_v_r || cur_raw > lo2_raw_r)) begin
              lo2_v_nxt    = 1'b1;
              lo2_raw_nxt  = cur_raw;
              lo2_true_nxt = cur_true;
            end
          end else if (cur_raw > sample_r) begin
            if (!hi_v_r || cur_raw < hi_raw_r) begin
              hi_v_nxt    = 1'b1;
              hi_raw_nxt  = cur_raw;
              hi_true_nxt = cur_true;
            end
          end
        end
      end

      // Pick the case and base; for the arithmetic cases set up offset, rise and run
      ST_SETUP: begin
        quo_nxt = '0;
        rem_nxt = '0;
        cnt_nxt = '0;
        neg_nxt = 1'b0;
        if (match_r) begin
          code_nxt = CASE_EXACT;
          base_nxt = match_true_r;
        end else if (!any_r) begin
          code_nxt = CASE_NO_POINTS;
          base_nxt = '0;
        end else begin
          if (lo_v_r && hi_v_r) begin
            code_nxt = CASE_INTERP;
            base_nxt = lo_true_r;
            off_nxt  = sample_r - lo_raw_r;
            run_nxt  = hi_raw_r - lo_raw_r;
            rise_s   = RISE_W'(hi_true_r) - RISE_W'(lo_true_r);
          end else if (lo_v_r && lo2_v_r) begin
            code_nxt = CASE_EXTRAP_TWO;
            base_nxt = lo_true_r;
            off_nxt  = sample_r - lo_raw_r;
            run_nxt  = lo_raw_r - lo2_raw_r;
            rise_s   = RISE_W'(lo_true_r) - RISE_W'(lo2_true_r);
          end else if (lo_v_r) begin
            code_nxt = CASE_ORIGIN_HI;
            base_nxt = lo_true_r;
            off_nxt  = sample_r - lo_raw_r;
            run_nxt  = lo_raw_r;
            rise_s   = RISE_W'(lo_true_r);
          end else begin
            code_nxt = CASE_ORIGIN_LO;
            base_nxt = '0;
            off_nxt  = sample_r;
            run_nxt  = hi_raw_r;
            rise_s   = RISE_W'(hi_true_r);
          end
          neg_nxt  = rise_s[RISE_W-1];
          rise_nxt = rise_s[RISE_W-1] ? RISE_W'(-rise_s) : RISE_W'(rise_s);
        end
      end

      ST_MULT: begin
        quo_nxt = DIV_W'(prod);
        rem_nxt = '0;
        cnt_nxt = '0;
      end

      // Restoring division, two quotient bits a cycle
      ST_DIV: begin
        quo_nxt = {quo_r[DIV_W-3:0], ge1, ge2};
        rem_nxt = r2;
        cnt_nxt = cnt_r + CNT_W'(1);
      end

      ST_FINISH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_code_nxt  = code_r;
          out_sat_nxt   = sat_hi || sat_lo;
          if (sat_hi)      out_value_nxt = {1'b0, {(TRUE_W-1){1'b1}}};
          else if (sat_lo) out_value_nxt = {1'b1, {(TRUE_W-1){1'b0}}};
          else             out_value_nxt = sum[TRUE_W-1:0];
        end
      end

      default: begin
        idx_nxt = '0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    sample_r     <= sample_nxt;
    idx_r        <= idx_nxt;
    any_r        <= any_nxt;
    match_r      <= match_nxt;
    match_true_r <= match_true_nxt;
    lo_v_r       <= lo_v_nxt;
    lo_raw_r     <= lo_raw_nxt;
    lo_true_r    <= lo_true_nxt;
    lo2_v_r      <= lo2_v_nxt;
    lo2_raw_r    <= lo2_raw_nxt;
    lo2_true_r   <= lo2_true_nxt;
    hi_v_r       <= hi_v_nxt;
    hi_raw_r     <= hi_raw_nxt;
    hi_true_r    <= hi_true_nxt;
    code_r       <= code_nxt;
    base_r       <= base_nxt;
    neg_r        <= neg_nxt;
    off_r        <= off_nxt;
    rise_r       <= rise_nxt;
    run_r        <= run_nxt;
    quo_r        <= quo_nxt;
    rem_r        <= rem_nxt;
    cnt_r        <= cnt_nxt;
    out_value_r  <= out_value_nxt;
    out_code_r   <= out_code_nxt;
    out_sat_r    <= out_sat_nxt;
  end

  // Checks
  a_accept_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == ST_SCAN)
    else $error("accepted request did not start the point scan");

  a_div_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> (run_r != '0) && (rem_r < run_r))
    else $error("divider remainder out of range or zero run");

  a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) && (cnt_r == CNT_LAST) |=> state_r == ST_FINISH)
    else $error("divider did not finish after its last step");

  a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_FINISH)
    else $error("result appeared outside the finish step");

  a_sat_only_arith: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_sat_r |-> (out_code_r != CASE_EXACT) &&
                                 (out_code_r != CASE_NO_POINTS))
    else $error("clip flag set on an exact or empty result");

endmodule : calibration_point_interpolator

`default_nettype wire

/* tb/sv/calibration_checker.sv */
// Checker for the calibration point interpolator: mirrors the point registers,
// predicts each calibrated value and compares it with the result channel.
// Depends on cpi_pkg, cpi_in_if and cpi_out_if.
module calibration_checker #(
  parameter int NUM_POINTS = cpi_pkg::MAX_POINTS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  cpi_in_if                              in_ch,
  cpi_out_if                             out_ch,
  input  logic                           cfg_we,
  input  logic [cpi_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cpi_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             mismatches,
  output int                             pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import cpi_pkg::*;

  localparam longint TRUE_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam longint TRUE_MIN = -64'sh0000_0000_8000_0000;

  typedef struct packed {
    logic signed [TRUE_W-1:0] value;
    logic [CODE_W-1:0]        code;
    logic                     clipped;
  } cal_result_t;

  // Local copy of the point registers
  logic [RAW_W-1:0]         point_raw  [MAX_POINTS];
  logic signed [TRUE_W-1:0] point_true [MAX_POINTS];

  cal_result_t calibrations_due [$];
  cal_result_t want;

  initial mismatches = 0;
  initial pending = 0;

  // Exact quotient rounded half away from zero; den is always positive
  function automatic longint round_half_away(input longint num, input longint den);
    longint mag, q;
    mag = (num < 0) ? -num : num;
    q = (2 * mag + den) / (2 * den);
    return (num < 0) ? -q : q;
  endfunction

  function automatic cal_result_t calibrate(input logic [RAW_W-1:0] smp);
    int lo, lo2, hi;
    bit any_used;
    longint s, base, off, rise, run, acc;
    longint raw_l [MAX_POINTS];
    longint true_l [MAX_POINTS];
    bit used [MAX_POINTS];
    cal_result_t r;
    lo = -1;
    lo2 = -1;
    hi = -1;
    any_used = 1'b0;
    s = longint'(smp);
    r = '{value: '0, code: CASE_NO_POINTS, clipped: 1'b0};
    for (int i = 0; i < MAX_POINTS; i++) begin
      raw_l[i] = longint'(point_raw[i]);
      true_l[i] = longint'(point_true[i]);
      used[i] = (i < NUM_POINTS) && (point_raw[i] != '0);
    end

    // Scan: exact match wins at once, else nearest lesser and greater point
    for (int i = 0; i < MAX_POINTS; i++) begin
      if (used[i]) begin
        any_used = 1'b1;
        if (raw_l[i] == s) begin
          r.value = point_true[i];
          r.code = CASE_EXACT;
          return r;
        end
        if (raw_l[i] < s) begin
          if (lo < 0 || raw_l[i] > raw_l[lo]) lo = i;
        end else begin
          if (hi < 0 || raw_l[i] < raw_l[hi]) hi = i;
        end
      end
    end
    if (!any_used) return r;

    // Second lesser point, strictly below the nearest one
    if (lo >= 0) begin
      for (int i = 0; i < MAX_POINTS; i++) begin
        if (used[i] && raw_l[i] < raw_l[lo] && (lo2 < 0 || raw_l[i] > raw_l[lo2]))
          lo2 = i;
      end
    end

    if (lo >= 0 && hi >= 0) begin
      r.code = CASE_INTERP;
      base = true_l[lo];
      off = s - raw_l[lo];
      rise = true_l[hi] - true_l[lo];
      run = raw_l[hi] - raw_l[lo];
    end else if (lo >= 0 && lo2 >= 0) begin
      r.code = CASE_EXTRAP_TWO;
      base = true_l[lo];
      off = s - raw_l[lo];
      rise = true_l[lo] - true_l[lo2];
      run = raw_l[lo] - raw_l[lo2];
    end else if (lo >= 0) begin
      r.code = CASE_ORIGIN_HI;
      base = true_l[lo];
      off = s - raw_l[lo];
      rise = true_l[lo];
      run = raw_l[lo];
    end else begin
      r.code = CASE_ORIGIN_LO;
      base = 0;
      off = s;
      rise = true_l[hi];
      run = raw_l[hi];
    end
    acc = base + round_half_away(off * rise, run);

    // Clip to signed 32 bits
    if (acc > TRUE_MAX) begin
      acc = TRUE_MAX;
      r.clipped = 1'b1;
    end else if (acc < TRUE_MIN) begin
      acc = TRUE_MIN;
      r.clipped = 1'b1;
    end
    r.value = acc[TRUE_W-1:0];
    return r;
  endfunction

  task automatic note_mismatch(input string field, input longint expected,
                               input longint actual);
    $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, expected, actual);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_POINTS; i++) begin
        point_raw[i] = '0;
        point_true[i] = '0;
      end
      calibrations_due.delete();
    end else begin
      // Result side: compare with the oldest outstanding request
      if (out_ch.valid && out_ch.ready) begin
        if (calibrations_due.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual value %0d case %0d clip %0b",
                   $time, out_ch.calibrated_value, out_ch.case_code, out_ch.saturated);
          mismatches++;
        end else begin
          want = calibrations_due.pop_front();
          if (out_ch.calibrated_value !== want.value)
            note_mismatch("calibrated_value", want.value, out_ch.calibrated_value);
          if (out_ch.case_code !== want.code)
            note_mismatch("case_code", want.code, out_ch.case_code);
          if (out_ch.saturated !== want.clipped)
            note_mismatch("saturated", want.clipped, out_ch.saturated);
        end
      end
      // Request side
      if (in_ch.valid && in_ch.ready)
        calibrations_due.push_back(calibrate(in_ch.raw_sample));
      // Register writes
      if (cfg_we) begin
        if (cfg_index < REG_TRUE_BASE)
          point_raw[cfg_index - REG_RAW_BASE] = cfg_data[RAW_W-1:0];
        else
          point_true[cfg_index - REG_TRUE_BASE] = cfg_data[TRUE_W-1:0];
      end
    end
    pending <= calibrations_due.size();
  end

endmodule : calibration_checker

/* tb/sv/testbench.sv */
// Top of the interpolator testbench: clock, reset, point setup and sample stimulus,
// random idling on both channels, watchdog and verdict.
// Depends on cpi_pkg, cpi_in_if, cpi_out_if, the interpolator and calibration_checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import cpi_pkg::*;

  localparam int QUIET_LIMIT = 3000;
  localparam int RANDOM_PHASES = 14;
  localparam int PHASE_ITEMS = 125;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  recv_ready = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    mismatches;
  int                    pending;
  int                    send_idle_pct = 0;
  int                    recv_stall_pct = 0;
  int                    quiet_cycles = 0;
  logic [RAW_W-1:0]      pt_raw [MAX_POINTS] = '{default: '0};

  cpi_in_if  in_ch ();
  cpi_out_if out_ch ();

  assign out_ch.ready = recv_ready;

  calibration_point_interpolator u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  calibration_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always #2 clk = ~clk;

  // Result side back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      recv_ready <= 1'b0;
    end else begin
      recv_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: cycles without any handshake
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Hold requests until every outstanding result has been taken
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic load_points(input logic [RAW_W-1:0] raws [MAX_POINTS],
                             input logic [TRUE_W-1:0] trues [MAX_POINTS]);
    drain();
    for (int i = 0; i < MAX_POINTS; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= REG_RAW_BASE + CFG_IDX_W'(i);
      cfg_data <= CFG_DATA_W'(raws[i]);
      pt_raw[i] = raws[i];
      @(posedge clk);
    end
    for (int i = 0; i < MAX_POINTS; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= REG_TRUE_BASE + CFG_IDX_W'(i);
      cfg_data <= CFG_DATA_W'(trues[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // Valid stays high after the accept; the next call either idles or reloads it
  task automatic send_sample(input logic [RAW_W-1:0] smp);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.raw_sample <= smp;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Clustered raws give duplicates, neighbors and exact hits
  task automatic random_points();
    logic [RAW_W-1:0]  raws [MAX_POINTS];
    logic [TRUE_W-1:0] trues [MAX_POINTS];
    for (int i = 0; i < MAX_POINTS; i++) begin
      case ($urandom_range(9))
        0, 1: raws[i] = '0;
        2: raws[i] = '1;
        3: raws[i] = RAW_W'(1);
        4: begin
          if (i > 0) raws[i] = raws[$urandom_range(i - 1)];
          else raws[i] = RAW_W'($urandom);
        end
        5, 6: raws[i] = RAW_W'(1000 + $urandom_range(40));
        default: raws[i] = RAW_W'($urandom);
      endcase
      case ($urandom_range(7))
        0: trues[i] = 32'h8000_0000;
        1: trues[i] = 32'h7FFF_FFFF;
        2, 3: trues[i] = TRUE_W'($urandom_range(2000)) - TRUE_W'(1000);
        default: trues[i] = TRUE_W'($urandom);
      endcase
    end
    load_points(raws, trues);
  endtask

  function automatic logic [RAW_W-1:0] pick_sample();
    logic [RAW_W-1:0] near;
    near = pt_raw[$urandom_range(MAX_POINTS - 1)];
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2, 3: return near;
      4: return near + RAW_W'($urandom_range(3));
      5: return near - RAW_W'($urandom_range(3));
      default: return RAW_W'($urandom);
    endcase
  endfunction

  initial begin
    in_ch.valid = 1'b0;
    in_ch.raw_sample = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Points at reset: nothing in use
    send_sample('0);
    send_sample('1);
    send_sample(RAW_W'(1234));

    // Mixed order, rounding both ways, extreme true values, full-scale raw
    load_points('{16'd100, 16'd300, 16'd200, 16'hFFFF},
                '{-32'sd7, 32'h7FFF_FFFF, 32'd10, 32'h8000_0000});
    send_sample(RAW_W'(0));
    send_sample(RAW_W'(50));
    send_sample(RAW_W'(100));
    send_sample(RAW_W'(150));
    send_sample(RAW_W'(200));
    send_sample(RAW_W'(250));
    send_sample(RAW_W'(65534));
    send_sample(RAW_W'(65535));

    // Duplicate raws, two lesser points above, clipping high
    load_points('{16'd40000, 16'd40000, 16'd20000, 16'd0},
                '{32'h7FFF_FFFF, 32'd5, 32'h8000_0000, 32'd0});
    send_sample(RAW_W'(40000));
    send_sample(RAW_W'(65535));
    send_sample(RAW_W'(10000));
    send_sample(RAW_W'(30000));

    // Single point at the bottom; an unused slot carries a true value
    load_points('{16'd0, 16'd0, 16'd0, 16'd1},
                '{32'd12345, 32'd0, 32'd0, 32'd3});
    send_sample(RAW_W'(0));
    send_sample(RAW_W'(1));
    send_sample(RAW_W'(65535));

    // Single point, origin extrapolation clipping low
    load_points('{16'd0, 16'h8000, 16'd0, 16'd0},
                '{32'd0, 32'h8000_0000, 32'd0, 32'd0});
    send_sample(RAW_W'(65535));
    send_sample(RAW_W'(1));

    // Random points and samples across idling modes
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      random_points();
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
        default: begin send_idle_pct = 30; recv_stall_pct = 30; end
      endcase
      repeat (PHASE_ITEMS) send_sample(pick_sample());
    end

    drain();
    repeat (40) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule : testbench

/* sim.f */
design/cpi_pkg.sv
design/cpi_in_if.sv
design/cpi_out_if.sv
design/calibration_point_interpolator.sv
tb/sv/calibration_checker.sv
tb/sv/testbench.sv
